// ===== rtl/kti_pkg.sv =====
// ----------------------------------------------------------------------------
// kti_pkg
// Shared types and constants for the keypad turbo and interrupt block.
// ----------------------------------------------------------------------------
package kti_pkg;

    // Key field width as carried on the stream ports
    localparam int KEY_W       = 10;
    localparam int CNT_W       = 8;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 10;

    typedef logic [KEY_W-1:0] t_keys;
    typedef logic [CNT_W-1:0] t_cnt;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_TURBO_FRAMES = 3'd0,
        CFG_TURBO_PULSE  = 3'd1,
        CFG_IRQ_ENABLE   = 3'd2,
        CFG_IRQ_AND_MODE = 3'd3,
        CFG_IRQ_KEY_MASK = 3'd4
    } t_cfg_addr;

    // Reset values of the configuration registers
    localparam t_cnt  TURBO_FRAMES_RST = 8'd4;
    localparam t_cnt  TURBO_PULSE_RST  = 8'd2;
    localparam t_keys IRQ_MASK_RST     = '0;

    // Settings seen by one turbo channel
    typedef struct packed {
        t_cnt period;
        t_cnt pulse_width;
    } t_turbo_cfg;

    // Settings seen by the interrupt condition
    typedef struct packed {
        logic  enable;
        logic  and_mode;
        t_keys key_mask;
    } t_irq_cfg;

endpackage

// ===== rtl/kti_turbo.sv =====
// ----------------------------------------------------------------------------
// kti_turbo
// One turbo channel: frame counter that gates a forced button press.
// ----------------------------------------------------------------------------
module kti_turbo
    import kti_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_advance,
    input  logic       i_held,
    input  t_turbo_cfg i_cfg,
    output logic       o_pressed
);

    t_cnt         r_count;
    t_cnt         n_count;
    logic [CNT_W:0] w_inc;

    // Press while the counter sits inside the pulse window
    assign o_pressed = i_held && (r_count < i_cfg.pulse_width);

    // Advance, wrap at the period, clear on release
    always_comb begin
        w_inc = {1'b0, r_count} + {{CNT_W{1'b0}}, 1'b1};
        if (!i_held) begin
            n_count = '0;
        end else if (w_inc >= {1'b0, i_cfg.period}) begin
            n_count = '0;
        end else begin
            n_count = w_inc[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_advance) begin
            r_count <= n_count;
        end
    end

endmodule

// ===== rtl/kti_irq.sv =====
// ----------------------------------------------------------------------------
// kti_irq
// Keypad interrupt condition with new-press detection against the last frame.
// ----------------------------------------------------------------------------
module kti_irq
    import kti_pkg::*;
#(
    parameter int KEY_COUNT = 10
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_advance,
    input  t_keys    i_keys,
    input  t_irq_cfg i_cfg,
    output logic     o_irq
);

    localparam t_keys KEY_MASK = t_keys'((32'd1 << KEY_COUNT) - 32'd1);

    t_keys r_prev_keys;
    t_keys w_mask;
    t_keys w_hit;
    logic  w_new_press;
    logic  w_cond;

    // Evaluate the condition only on a fresh press
    always_comb begin
        w_mask      = i_cfg.key_mask & KEY_MASK;
        w_hit       = i_keys & w_mask;
        w_new_press = |(i_keys & ~r_prev_keys);
        w_cond      = i_cfg.and_mode ? (w_hit == w_mask) : (|w_hit);
        o_irq       = w_new_press && i_cfg.enable && w_cond;
    end

    // Hold the effective keys of the last frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_keys <= '0;
        end else if (i_advance) begin
            r_prev_keys <= i_keys;
        end
    end

endmodule

// ===== rtl/keypad_turbo_and_interrupt.sv =====
// ----------------------------------------------------------------------------
// keypad_turbo_and_interrupt
// Per-frame keypad turbo insertion and keypad interrupt request.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one frame of keypad input per transfer: the pressed
//   key mask and the two turbo-hold flags. Master stream returns one result
//   per frame: the active-low key status and a one-frame irq request.
//   Configuration is written through i_cfg_we / i_cfg_addr / i_cfg_wdata
//   while no frame is in flight; unknown indexes are ignored.
// Pipeline and throughput:
//   A transfer lands in the input register, is evaluated combinationally and
//   lands in the result register. One frame is accepted every cycle while
//   the result register is not stalled; the turbo counters and previous-keys
//   register update in the same cycle a frame moves into the result register.
// Reset:
//   Synchronous, active low. Both stream stages empty, counters and previous
//   keys cleared, configuration back to period 4, pulse 2, irq disabled.
// Back-pressure:
//   A stalled result holds in the result register while one more frame waits
//   in the input register; s_axis_tready drops only when both are full.
// ----------------------------------------------------------------------------
module keypad_turbo_and_interrupt
    import kti_pkg::*;
#(
    parameter int KEY_COUNT = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write port
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    // Input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [9:0] pressed_keys, [10] turbo_a_held, [11] turbo_b_held, [15:12] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // Output stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [9:0] key_status, [10] irq_raise, [15:11] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam t_keys KEY_MASK = t_keys'((32'd1 << KEY_COUNT) - 32'd1);

    // Configuration registers
    t_cnt  r_turbo_frames;
    t_cnt  r_turbo_pulse;
    logic  r_irq_enable;
    logic  r_irq_and_mode;
    t_keys r_irq_key_mask;

    // Input register
    logic  r_in_valid;
    t_keys r_in_keys;
    logic  r_in_turbo_a;
    logic  r_in_turbo_b;

    // Result register
    logic  r_out_valid;
    t_keys r_out_status;
    logic  r_out_irq;

    logic       w_advance;
    logic       w_turbo_a;
    logic       w_turbo_b;
    t_keys      w_keys;
    logic       w_irq;
    t_turbo_cfg w_turbo_cfg;
    t_irq_cfg   w_irq_cfg;

    // Write configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turbo_frames <= TURBO_FRAMES_RST;
            r_turbo_pulse  <= TURBO_PULSE_RST;
            r_irq_enable   <= 1'b0;
            r_irq_and_mode <= 1'b0;
            r_irq_key_mask <= IRQ_MASK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_TURBO_FRAMES: r_turbo_frames <= i_cfg_wdata[CNT_W-1:0];
                CFG_TURBO_PULSE:  r_turbo_pulse  <= i_cfg_wdata[CNT_W-1:0];
                CFG_IRQ_ENABLE:   r_irq_enable   <= i_cfg_wdata[0];
                CFG_IRQ_AND_MODE: r_irq_and_mode <= i_cfg_wdata[0];
                CFG_IRQ_KEY_MASK: r_irq_key_mask <= i_cfg_wdata[KEY_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_turbo_cfg = '{period: r_turbo_frames, pulse_width: r_turbo_pulse};
    assign w_irq_cfg   = '{enable: r_irq_enable, and_mode: r_irq_and_mode,
                           key_mask: r_irq_key_mask};

    // Move the input register forward when the result register frees up
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_keys    <= s_axis_tdata[KEY_W-1:0];
            r_in_turbo_a <= s_axis_tdata[KEY_W];
            r_in_turbo_b <= s_axis_tdata[KEY_W+1];
        end
    end

    // Turbo channels: A forces bit 0, B forces bit 1
    kti_turbo u_turbo_a (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_held    (r_in_turbo_a),
        .i_cfg     (w_turbo_cfg),
        .o_pressed (w_turbo_a)
    );

    kti_turbo u_turbo_b (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_held    (r_in_turbo_b),
        .i_cfg     (w_turbo_cfg),
        .o_pressed (w_turbo_b)
    );

    // Merge turbo presses into the frame's key mask
    assign w_keys = (r_in_keys | {{(KEY_W-2){1'b0}}, w_turbo_b, w_turbo_a}) & KEY_MASK;

    kti_irq #(
        .KEY_COUNT (KEY_COUNT)
    ) u_irq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_keys    (w_keys),
        .i_cfg     (w_irq_cfg),
        .o_irq     (w_irq)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_status <= ~w_keys & KEY_MASK;
            r_out_irq    <= w_irq;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-KEY_W-1){1'b0}}, r_out_irq, r_out_status};

endmodule

// ===== rtl/kti_checker.sv =====
// ----------------------------------------------------------------------------
// kti_checker
// Port-level checks for the keypad turbo and interrupt block.
// ----------------------------------------------------------------------------
module kti_checker
    import kti_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // Reset empties the result stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Padding bits above irq_raise stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:KEY_W+1] == '0)
        else $error("result padding not zero");

    // An empty result stage never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result stage");

    // A transfer passes through the input register into the result stage when the receiver takes results
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("result missing two cycles after transfer");

endmodule

bind keypad_turbo_and_interrupt kti_checker u_kti_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== bench/tb_keypad_turbo_and_interrupt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keypad_turbo_and_interrupt
// Self-checking bench for the keypad turbo and keypad interrupt block.
// ----------------------------------------------------------------------------
// A frame queue feeds a clocked stream driver. Every accepted frame runs
// through a local copy of the turbo counters, previous-keys register and
// interrupt condition, and the predicted key status goes into a FIFO. A
// clocked monitor checks each returned transfer against the oldest
// prediction. Register settings change between phases, only once the block
// has drained. The directed frames come first, then randomized key
// sequences with held turbo runs. Both stream sides insert random gaps, and
// the output side applies one long back-pressure stall.
// ----------------------------------------------------------------------------
module tb_keypad_turbo_and_interrupt;
    import kti_pkg::*;

    localparam int FRAME_W     = KEY_W + 2;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_LEN   = 75;
    localparam int PACE_STEP   = 208;
    localparam int HOLD_AT     = 500;
    localparam int HOLD_CYCLES = 60;
    localparam int WATCHDOG    = 2000;

    // One frame as carried in s_axis_tdata, lowest bits last in the list
    typedef struct packed {
        logic  turbo_b;
        logic  turbo_a;
        t_keys keys;
    } frame_t;

    // One result as carried in m_axis_tdata
    typedef struct packed {
        logic  irq_raise;
        t_keys key_status;
    } status_t;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata   = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [9:0] pressed_keys, [10] turbo_a_held, [11] turbo_b_held, [15:12] zero
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [9:0] key_status, [10] irq_raise, [15:11] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    keypad_turbo_and_interrupt uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Register mirror, at reset values
    t_cnt  turbo_frames = TURBO_FRAMES_RST;
    t_cnt  pulse_width  = TURBO_PULSE_RST;
    logic  irq_en       = 1'b0;
    logic  irq_all      = 1'b0;
    t_keys irq_mask     = IRQ_MASK_RST;

    // Frame state mirror
    t_keys last_keys    = '0;
    t_cnt  turbo_a_cnt  = '0;
    t_cnt  turbo_b_cnt  = '0;

    frame_t  pending_frames[$];
    status_t expected_status[$];
    int      frames_sent   = 0;
    int      results_seen  = 0;
    int      errors        = 0;
    int      stall_left    = 0;
    logic    stall_done    = 1'b0;
    int      quiet_cycles  = 0;

    // Random key sequence state
    t_keys   stim_keys     = '0;
    logic    stim_ta       = 1'b0;
    logic    stim_tb       = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Advance a turbo counter: clear on release, wrap at the period
    function automatic t_cnt next_turbo_count(input logic held, input t_cnt cnt);
        logic [CNT_W:0] nxt;
        if (!held)
            return '0;
        nxt = {1'b0, cnt} + 1'b1;
        if (nxt >= {1'b0, turbo_frames})
            nxt = '0;
        return nxt[CNT_W-1:0];
    endfunction

    // Work out the key status and irq for one frame and queue it
    function automatic void compute_key_status(input frame_t f);
        t_keys keys;
        t_keys hit;
        logic  irq;
        keys = f.keys;
        if (f.turbo_a && turbo_a_cnt < pulse_width)
            keys[0] = 1'b1;
        if (f.turbo_b && turbo_b_cnt < pulse_width)
            keys[1] = 1'b1;
        turbo_a_cnt = next_turbo_count(f.turbo_a, turbo_a_cnt);
        turbo_b_cnt = next_turbo_count(f.turbo_b, turbo_b_cnt);
        irq = 1'b0;
        if (((keys | last_keys) != last_keys) && irq_en) begin
            hit = keys & irq_mask;
            irq = irq_all ? (hit == irq_mask) : (hit != '0);
        end
        last_keys = keys;
        expected_status.push_back(status_t'{irq_raise: irq, key_status: ~keys});
    endfunction

    function automatic int sender_gap_pct();
        if (frames_sent < PACE_STEP)
            return 37;
        if (frames_sent < 2 * PACE_STEP)
            return 87;
        return 0;
    endfunction

    function automatic int receiver_gap_pct();
        if (results_seen < PACE_STEP)
            return 87;
        if (results_seen < 2 * PACE_STEP)
            return 37;
        return 0;
    endfunction

    // Stream driver: predict on each transfer, then offer the next frame
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                compute_key_status(frame_t'(s_axis_tdata[FRAME_W-1:0]));
                frames_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_frames.size() != 0 && $urandom_range(0, 99) >= sender_gap_pct()) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {{(IN_TDATA_W - FRAME_W){1'b0}}, pending_frames.pop_front()};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each transfer with the oldest prediction
    always @(posedge i_clk) begin
        status_t want;
        status_t got;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = status_t'(m_axis_tdata[KEY_W:0]);
                if (expected_status.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_axis_tdata);
                    errors++;
                end else begin
                    want = expected_status.pop_front();
                    if (got.key_status !== want.key_status) begin
                        $display("%0t: key_status expected %h actual %h",
                                 $time, want.key_status, got.key_status);
                        errors++;
                    end
                    if (got.irq_raise !== want.irq_raise) begin
                        $display("%0t: irq_raise expected %b actual %b",
                                 $time, want.irq_raise, got.irq_raise);
                        errors++;
                    end
                    if (m_axis_tdata[OUT_TDATA_W-1:KEY_W+1] !== '0) begin
                        $display("%0t: tdata padding expected 0 actual %h",
                                 $time, m_axis_tdata[OUT_TDATA_W-1:KEY_W+1]);
                        errors++;
                    end
                end
                results_seen++;
            end
            // Hold off once for a long stretch so the block backs up its input
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (results_seen == HOLD_AT && !stall_done) begin
                stall_done = 1'b1;
                stall_left = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= receiver_gap_pct());
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Wait until every frame is out and every result is back
    task automatic drain();
        do
            @(negedge i_clk);
        while (pending_frames.size() != 0 || s_axis_tvalid || expected_status.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_addr addr, input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        case (addr)
            CFG_TURBO_FRAMES: turbo_frames = value[CNT_W-1:0];
            CFG_TURBO_PULSE:  pulse_width  = value[CNT_W-1:0];
            CFG_IRQ_ENABLE:   irq_en       = value[0];
            CFG_IRQ_AND_MODE: irq_all      = value[0];
            CFG_IRQ_KEY_MASK: irq_mask     = value[KEY_W-1:0];
            default: ;
        endcase
    endtask

    // Drain, then rewrite every register
    task automatic set_config(input int period, input int pulse, input logic en,
                              input logic all_keys, input t_keys mask);
        drain();
        write_reg(CFG_TURBO_FRAMES, CFG_DATA_W'(period));
        write_reg(CFG_TURBO_PULSE, CFG_DATA_W'(pulse));
        write_reg(CFG_IRQ_ENABLE, CFG_DATA_W'(en));
        write_reg(CFG_IRQ_AND_MODE, CFG_DATA_W'(all_keys));
        write_reg(CFG_IRQ_KEY_MASK, CFG_DATA_W'(mask));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_frame(input t_keys keys, input logic ta, input logic tb);
        pending_frames.push_back(frame_t'{turbo_b: tb, turbo_a: ta, keys: keys});
    endtask

    // Mostly single-key changes and held turbo runs, with some noise
    task automatic add_random_frames(input int count, input int flip_pct);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 15);
            if (pick == 0)
                stim_keys = '0;
            else if (pick == 1)
                stim_keys = '1;
            else if (pick < 4)
                stim_keys = t_keys'($urandom_range(0, 1023));
            else if (pick < 13)
                stim_keys = stim_keys ^ (t_keys'(1) << $urandom_range(0, KEY_W - 1));
            if ($urandom_range(0, 99) < flip_pct)
                stim_ta = ~stim_ta;
            if ($urandom_range(0, 99) < flip_pct)
                stim_tb = ~stim_tb;
            add_frame(stim_keys, stim_ta, stim_tb);
        end
    endtask

    function automatic t_keys random_mask();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return t_keys'(1) << $urandom_range(0, KEY_W - 1);
            default: return t_keys'($urandom_range(0, 1023));
        endcase
    endfunction

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty mask in AND mode: any new press fires
        set_config(4, 2, 1'b1, 1'b1, '0);
        add_frame('0, 1'b0, 1'b0);
        add_frame('1, 1'b0, 1'b0);
        add_frame('1, 1'b0, 1'b0);
        add_frame('0, 1'b0, 1'b0);
        add_frame(10'h200, 1'b0, 1'b0);
        repeat (5) add_frame('0, 1'b1, 1'b1);

        // Zero pulse width, OR mode over all keys
        set_config(1, 0, 1'b1, 1'b0, '1);
        add_frame(10'h001, 1'b0, 1'b0);
        add_frame('0, 1'b0, 1'b0);
        add_frame(10'h155, 1'b1, 1'b1);
        add_frame(10'h2AA, 1'b1, 1'b0);

        // Pulse width at the period: turbo always reads pressed
        set_config(255, 255, 1'b1, 1'b1, 10'h003);
        add_frame(10'h002, 1'b1, 1'b0);
        repeat (3) add_frame('0, 1'b1, 1'b1);

        // Period dropped below the running counters
        set_config(2, 1, 1'b1, 1'b0, 10'h002);
        repeat (2) add_frame('0, 1'b1, 1'b1);

        // Zero period with the interrupt disabled
        set_config(0, 1, 1'b0, 1'b0, 10'h001);
        repeat (3) add_frame('0, 1'b1, 1'b1);
        add_frame('1, 1'b0, 1'b0);

        // Random phases, each under its own register setting
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: set_config(255, 255, 1'b1, 1'b0, '1);
                1: set_config(1, 0, 1'b1, 1'b1, '0);
                2: set_config(4, 2, 1'b1, 1'b1, '1);
                3: set_config(0, $urandom_range(0, 3), 1'b1, 1'b0, random_mask());
                default: set_config($urandom_range(1, 8), $urandom_range(0, 9),
                                    $urandom_range(0, 4) != 0, $urandom_range(0, 1),
                                    random_mask());
            endcase
            add_random_frames(PHASE_LEN, (p == 0) ? 3 : 10);
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (expected_status.size() != 0)
            errors++;
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/kti_pkg.sv
rtl/kti_turbo.sv
rtl/kti_irq.sv
rtl/keypad_turbo_and_interrupt.sv
rtl/kti_checker.sv
bench/tb_keypad_turbo_and_interrupt.sv
